// ===== src/i2cms_pkg.sv =====
`default_nettype none
package i2cms_pkg;

  localparam int CMD_W   = 3;
  localparam int TICKS_W = 16;
  localparam int PROD_W  = TICKS_W + 2;
  localparam int PHASE_W = 5;

  localparam logic [CMD_W-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ACK   = 3'd5;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd72;

  typedef struct packed {
    logic       rejected;
    logic       nack_seen;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_driving;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage
`default_nettype wire

// ===== src/i2c_master_bit_sequencer_top.sv =====
`default_nettype none
// Channel   Direction  Payload (lowest bit first)
// s_*       in         tdata: data_byte[7:0], ack_bit, sda_sample; tuser: command[2:0]
// m_*       out        tdata: scl, sda, sda_driving, busy, done, read_byte[7:0], nack, rejected
// cfg_*     in         data: ticks_per_us[15:0]
//
// Each item is decoded and the sequencer state updated at the
// accepting edge, and the result sits in the output register from the next cycle.
// A new item is taken every cycle while the output register is empty or being taken.
// Synchronous reset clears the sequencer to idle with SCL and SDA driven high.
// A stalled output holds the result and stops input acceptance.
module i2c_master_bit_sequencer_top #(
  parameter int DELAY_COUNT_WIDTH = 20
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  input  wire logic [15:0]                      s_tdata,  // data_byte, ack_bit, sda_sample
  input  wire logic [i2cms_pkg::CMD_W-1:0]      s_tuser,  // command
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [15:0]                      m_tdata,  // see table above
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [i2cms_pkg::TICKS_W-1:0]    cfg_data
);
  import i2cms_pkg::*;

  localparam int DW = DELAY_COUNT_WIDTH;
  localparam logic [31:0] DMAX = 32'((64'd1 << DW) - 64'd1);

  localparam logic [PHASE_W-1:0] PH_IDLE    = 5'd0;
  localparam logic [PHASE_W-1:0] PH_ST1     = 5'd1;
  localparam logic [PHASE_W-1:0] PH_ST2     = 5'd2;
  localparam logic [PHASE_W-1:0] PH_SP1     = 5'd3;
  localparam logic [PHASE_W-1:0] PH_SP2     = 5'd4;
  localparam logic [PHASE_W-1:0] PH_SP3     = 5'd5;
  localparam logic [PHASE_W-1:0] PH_WB_LOW  = 5'd6;
  localparam logic [PHASE_W-1:0] PH_WB_DATA = 5'd7;
  localparam logic [PHASE_W-1:0] PH_WB_HIGH = 5'd8;
  localparam logic [PHASE_W-1:0] PH_WA_PRE  = 5'd9;
  localparam logic [PHASE_W-1:0] PH_WA_REL  = 5'd10;
  localparam logic [PHASE_W-1:0] PH_WA_HIGH = 5'd11;
  localparam logic [PHASE_W-1:0] PH_WA_END  = 5'd12;
  localparam logic [PHASE_W-1:0] PH_RB_PRE  = 5'd13;
  localparam logic [PHASE_W-1:0] PH_RB_REL  = 5'd14;
  localparam logic [PHASE_W-1:0] PH_RB_HIGH = 5'd15;
  localparam logic [PHASE_W-1:0] PH_RB_LOW  = 5'd16;
  localparam logic [PHASE_W-1:0] PH_AK1     = 5'd17;
  localparam logic [PHASE_W-1:0] PH_AK2     = 5'd18;
  localparam logic [PHASE_W-1:0] PH_AK3     = 5'd19;
  localparam logic [PHASE_W-1:0] PH_AK4     = 5'd20;

  logic [TICKS_W-1:0] ticks_per_us;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [DW-1:0]      delay_left, delay_left_next;
  logic               scl_reg, scl_reg_next;
  logic               sda_reg, sda_reg_next;
  logic               sda_drive_reg, sda_drive_reg_next;
  logic               nack_reg, nack_reg_next;
  logic               ack_value, ack_value_next;
  logic [7:0]         read_latch, read_latch_next;
  logic               done, rej;
  logic               accept;
  result_t            res;

  logic [DW-1:0] d1, d2, d4;

  logic [CMD_W-1:0] cmd;
  logic [7:0]       data_byte;
  logic             ack_bit;
  logic             sda_sample;

  assign cmd        = s_tuser;
  assign data_byte  = s_tdata[7:0];
  assign ack_bit    = s_tdata[8];
  assign sda_sample = s_tdata[9];

  function automatic logic [DW-1:0] scale_delay(input logic [PROD_W-1:0] prod);
    logic [31:0] p;
    logic [31:0] v;
    p = 32'(prod);
    v = p;
    if (p == 32'd0) begin
      v = 32'd1;
    end else if (p > DMAX) begin
      v = DMAX;
    end
    return DW'(v);
  endfunction

  assign d1 = scale_delay(PROD_W'(ticks_per_us));
  assign d2 = scale_delay(PROD_W'({ticks_per_us, 1'b0}));
  assign d4 = scale_delay(PROD_W'({ticks_per_us, 2'b00}));

  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    delay_left_next    = delay_left;
    scl_reg_next       = scl_reg;
    sda_reg_next       = sda_reg;
    sda_drive_reg_next = sda_drive_reg;
    nack_reg_next      = nack_reg;
    ack_value_next     = ack_value;
    read_latch_next    = read_latch;
    done               = 1'b0;
    rej                = 1'b0;

    if (cmd == CMD_TICK) begin
      if (phase != PH_IDLE) begin
        if (delay_left > DW'(1)) begin
          delay_left_next = delay_left - DW'(1);
        end else begin
          unique case (phase)
            PH_ST1: begin
              sda_reg_next = 1'b0; delay_left_next = d2; phase_next = PH_ST2;
            end
            PH_SP1: begin
              scl_reg_next = 1'b1; delay_left_next = d2; phase_next = PH_SP2;
            end
            PH_SP2: begin
              sda_reg_next = 1'b1; delay_left_next = d2; phase_next = PH_SP3;
            end
            PH_WB_LOW: begin
              sda_reg_next    = shift_byte[3'd7 - bit_index];
              delay_left_next = d1;
              phase_next      = PH_WB_DATA;
            end
            PH_WB_DATA: begin
              scl_reg_next = 1'b1; delay_left_next = d4; phase_next = PH_WB_HIGH;
            end
            PH_WB_HIGH: begin
              scl_reg_next    = 1'b0;
              delay_left_next = d1;
              if (bit_index != 3'd7) begin
                bit_index_next = bit_index + 3'd1;
                phase_next     = PH_WB_LOW;
              end else begin
                phase_next = PH_WA_PRE;
              end
            end
            PH_WA_PRE: begin
              sda_reg_next = 1'b1; delay_left_next = d1; phase_next = PH_WA_REL;
            end
            PH_WA_REL: begin
              sda_drive_reg_next = 1'b0;
              scl_reg_next       = 1'b1;
              delay_left_next    = d2;
              phase_next         = PH_WA_HIGH;
            end
            PH_WA_HIGH: begin
              nack_reg_next   = sda_sample;
              scl_reg_next    = 1'b0;
              delay_left_next = d1;
              phase_next      = PH_WA_END;
            end
            PH_RB_PRE: begin
              sda_reg_next = 1'b1; delay_left_next = d1; phase_next = PH_RB_REL;
            end
            PH_RB_REL: begin
              sda_drive_reg_next = 1'b0;
              bit_index_next     = 3'd0;
              scl_reg_next       = 1'b1;
              delay_left_next    = d1;
              phase_next         = PH_RB_HIGH;
            end
            PH_RB_HIGH: begin
              shift_byte_next = {shift_byte[6:0], sda_sample};
              scl_reg_next    = 1'b0;
              delay_left_next = d4;
              phase_next      = PH_RB_LOW;
            end
            PH_RB_LOW: begin
              if (bit_index != 3'd7) begin
                bit_index_next  = bit_index + 3'd1;
                scl_reg_next    = 1'b1;
                delay_left_next = d1;
                phase_next      = PH_RB_HIGH;
              end else begin
                read_latch_next = shift_byte;
                phase_next      = PH_IDLE;
                delay_left_next = '0;
                done            = 1'b1;
              end
            end
            PH_AK1: begin
              sda_reg_next = ack_value; delay_left_next = d1; phase_next = PH_AK2;
            end
            PH_AK2: begin
              scl_reg_next = 1'b1; delay_left_next = d2; phase_next = PH_AK3;
            end
            PH_AK3: begin
              scl_reg_next = 1'b0; delay_left_next = d1; phase_next = PH_AK4;
            end
            PH_ST2: begin
              scl_reg_next    = 1'b0;
              phase_next      = PH_IDLE;
              delay_left_next = '0;
              done            = 1'b1;
            end
            default: begin
              phase_next      = PH_IDLE;
              delay_left_next = '0;
              done            = 1'b1;
            end
          endcase
        end
      end
    end else if (cmd <= CMD_ACK) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        unique case (cmd)
          CMD_START: begin
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b1;
            sda_reg_next       = 1'b1;
            delay_left_next    = d2;
            phase_next         = PH_ST1;
          end
          CMD_STOP: begin
            sda_drive_reg_next = 1'b1;
            scl_reg_next       = 1'b0;
            sda_reg_next       = 1'b0;
            delay_left_next    = d2;
            phase_next         = PH_SP1;
          end
          CMD_WRITE: begin
            sda_drive_reg_next = 1'b1;
            shift_byte_next    = data_byte;
            bit_index_next     = 3'd0;
            scl_reg_next       = 1'b0;
            delay_left_next    = d1;
            phase_next         = PH_WB_LOW;
          end
          CMD_READ: begin
            shift_byte_next = 8'd0;
            bit_index_next  = 3'd0;
            scl_reg_next    = 1'b0;
            delay_left_next = d1;
            phase_next      = PH_RB_PRE;
          end
          default: begin
            ack_value_next     = ack_bit;
            scl_reg_next       = 1'b0;
            sda_drive_reg_next = 1'b1;
            delay_left_next    = d1;
            phase_next         = PH_AK1;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.scl_level   = scl_reg_next;
    res.sda_level   = sda_reg_next;
    res.sda_driving = sda_drive_reg_next;
    res.busy_res    = phase_next != PH_IDLE;
    res.done_res    = done;
    res.read_byte   = read_latch_next;
    res.nack_seen   = nack_reg_next;
    res.rejected    = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us  <= TICKS_RESET;
      phase         <= PH_IDLE;
      bit_index     <= 3'd0;
      shift_byte    <= 8'd0;
      delay_left    <= '0;
      scl_reg       <= 1'b1;
      sda_reg       <= 1'b1;
      sda_drive_reg <= 1'b1;
      nack_reg      <= 1'b0;
      ack_value     <= 1'b0;
      read_latch    <= 8'd0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ticks_per_us <= cfg_data;
      end
      if (accept) begin
        phase         <= phase_next;
        bit_index     <= bit_index_next;
        shift_byte    <= shift_byte_next;
        delay_left    <= delay_left_next;
        scl_reg       <= scl_reg_next;
        sda_reg       <= sda_reg_next;
        sda_drive_reg <= sda_drive_reg_next;
        nack_reg      <= nack_reg_next;
        ack_value     <= ack_value_next;
        read_latch    <= read_latch_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= 16'(res);
    end
  end

endmodule
`default_nettype wire
